// ===== rtl/nearest_site_labeler_core_assert.svh =====
// ----------------------------------------------------------------------------
// nearest_site_labeler_core assertion macros
// shared property forms for the labeler core, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_SITE_LABELER_CORE_ASSERT_SVH
`define NEAREST_SITE_LABELER_CORE_ASSERT_SVH

// same-cycle implication
`define NSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nsl_pkg.sv =====
// ----------------------------------------------------------------------------
// nsl_pkg
// shared types and constants of the nearest site labeler
// ----------------------------------------------------------------------------
package nsl_pkg;

	// integer pixel coordinate width
	localparam int PIX_BITS = 12;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// control that travels with each transaction along the chain
	typedef struct packed {
		logic vld;
		logic cmd;
	} ctl_t;

endpackage

// ===== rtl/nsl_cell.sv =====
// ----------------------------------------------------------------------------
// nsl_cell
// one site of the chain: holds a site position, scores a passing query
// against it and keeps the running best
// ----------------------------------------------------------------------------
module nsl_cell import nsl_pkg::*; #(
	parameter int CELL_ID    = 0,
	parameter int NUM_SITES  = 24,
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    l1_sel,
	input  ctl_t                                    ctl_i,
	input  logic [PIX_BITS+FRAC_BITS-1:0]           cx_i,
	input  logic [PIX_BITS+FRAC_BITS-1:0]           cy_i,
	input  logic [COORD_BITS-1:0]                   ldx_i,
	input  logic [COORD_BITS-1:0]                   ldy_i,
	input  logic [$clog2(NUM_SITES)-1:0]            lidx_i,
	input  logic [2*((COORD_BITS > PIX_BITS+FRAC_BITS) ?
		COORD_BITS : PIX_BITS+FRAC_BITS):0]         bestd_i,
	input  logic [$clog2(NUM_SITES)-1:0]            bestk_i,
	output ctl_t                                    ctl_o,
	output logic [PIX_BITS+FRAC_BITS-1:0]           cx_o,
	output logic [PIX_BITS+FRAC_BITS-1:0]           cy_o,
	output logic [COORD_BITS-1:0]                   ldx_o,
	output logic [COORD_BITS-1:0]                   ldy_o,
	output logic [$clog2(NUM_SITES)-1:0]            lidx_o,
	output logic [2*((COORD_BITS > PIX_BITS+FRAC_BITS) ?
		COORD_BITS : PIX_BITS+FRAC_BITS):0]         bestd_o,
	output logic [$clog2(NUM_SITES)-1:0]            bestk_o
);

	localparam int CW    = PIX_BITS + FRAC_BITS;
	localparam int DW    = (COORD_BITS > CW) ? COORD_BITS : CW;
	localparam int PW    = 2 * DW;
	localparam int DSW   = PW + 1;
	localparam int IDX_W = $clog2(NUM_SITES);
	localparam bit IS_FIRST = (CELL_ID == 0);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

	logic [COORD_BITS-1:0] site_x_q;
	logic [COORD_BITS-1:0] site_y_q;

	logic [DW-1:0]  ext_cx, ext_cy, sx, sy, dx, dy;
	logic [PW-1:0]  term_x, term_y;
	logic [DSW-1:0] dsum;
	logic           take;

	ctl_t                  ctl_s1, ctl_s2;
	logic [CW-1:0]         cx_s1, cy_s1, cx_s2, cy_s2;
	logic [COORD_BITS-1:0] ldx_s1, ldy_s1, ldx_s2, ldy_s2;
	logic [IDX_W-1:0]      lidx_s1, lidx_s2;
	logic [DSW-1:0]        bestd_s1, bestd_s2;
	logic [IDX_W-1:0]      bestk_s1, bestk_s2;
	logic [PW-1:0]         term_x_s1, term_y_s1;

	// site table entry of this cell, loaded as the load transaction passes
	always_ff @(posedge clk) begin
		if (en && ctl_i.vld && ctl_i.cmd == CMD_LOAD && lidx_i == MY_IDX) begin
			site_x_q <= ldx_i;
			site_y_q <= ldy_i;
		end
	end

	always_comb begin
		ext_cx = DW'(cx_i);
		ext_cy = DW'(cy_i);
		sx     = DW'(site_x_q);
		sy     = DW'(site_y_q);
		dx     = (ext_cx >= sx) ? ext_cx - sx : sx - ext_cx;
		dy     = (ext_cy >= sy) ? ext_cy - sy : sy - ext_cy;
		term_x = l1_sel ? PW'(dx) : PW'(dx) * PW'(dx);
		term_y = l1_sel ? PW'(dy) : PW'(dy) * PW'(dy);
	end

	// stage 1: per-axis terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1     <= cx_i;
			cy_s1     <= cy_i;
			ldx_s1    <= ldx_i;
			ldy_s1    <= ldy_i;
			lidx_s1   <= lidx_i;
			bestd_s1  <= bestd_i;
			bestk_s1  <= bestk_i;
			term_x_s1 <= term_x;
			term_y_s1 <= term_y;
		end
	end

	// stage 2: sum and compare, strict less keeps the lower index on ties
	always_comb begin
		dsum = DSW'(term_x_s1) + DSW'(term_y_s1);
		take = IS_FIRST || (dsum < bestd_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			ldx_s2   <= ldx_s1;
			ldy_s2   <= ldy_s1;
			lidx_s2  <= lidx_s1;
			bestd_s2 <= take ? dsum : bestd_s1;
			bestk_s2 <= take ? MY_IDX : bestk_s1;
		end
	end

	assign ctl_o   = ctl_s2;
	assign cx_o    = cx_s2;
	assign cy_o    = cy_s2;
	assign ldx_o   = ldx_s2;
	assign ldy_o   = ldy_s2;
	assign lidx_o  = lidx_s2;
	assign bestd_o = bestd_s2;
	assign bestk_o = bestk_s2;

endmodule

// ===== rtl/nearest_site_labeler_core.sv =====
// ----------------------------------------------------------------------------
// nearest_site_labeler_core
// voronoi labeler: returns the index of the site nearest to a pixel centre
// ----------------------------------------------------------------------------
// A chain of NUM_SITES cells, each holding one site. Every transaction, load
// or query, walks the chain in order through each cell's stage 1 and stage
// 2 registers, so one item can be accepted every cycle unless a result
// waits on the output. A load takes effect in its cell as it passes and
// gives no result; queries that follow it see the new position. The whole
// chain holds while a result waits on the output, so in_ready is low only
// then. The distance select register (cfg port, always ready, 1 selects
// manhattan) should be written only when the chain is empty.
module nearest_site_labeler_core import nsl_pkg::*; #(
	parameter int NUM_SITES  = 24,
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [$clog2(NUM_SITES)-1:0] site_index,
	input  logic [COORD_BITS-1:0]        site_x,
	input  logic [COORD_BITS-1:0]        site_y,
	input  logic [PIX_BITS-1:0]          pixel_x,
	input  logic [PIX_BITS-1:0]          pixel_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [$clog2(NUM_SITES)-1:0] nearest_site
);

	`include "nearest_site_labeler_core_assert.svh"

	localparam int CW    = PIX_BITS + FRAC_BITS;
	localparam int DW    = (COORD_BITS > CW) ? COORD_BITS : CW;
	localparam int DSW   = 2 * DW + 1;
	localparam int IDX_W = $clog2(NUM_SITES);
	localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

	logic l1_sel_q;
	logic en;

	ctl_t                  ctl_w   [NUM_SITES+1];
	logic [CW-1:0]         cx_w    [NUM_SITES+1];
	logic [CW-1:0]         cy_w    [NUM_SITES+1];
	logic [COORD_BITS-1:0] ldx_w   [NUM_SITES+1];
	logic [COORD_BITS-1:0] ldy_w   [NUM_SITES+1];
	logic [IDX_W-1:0]      lidx_w  [NUM_SITES+1];
	logic [DSW-1:0]        bestd_w [NUM_SITES+1];
	logic [IDX_W-1:0]      bestk_w [NUM_SITES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_sel_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			l1_sel_q <= cfg_data;
		end
	end

	// last cell's stage 2 doubles as the output register
	assign out_valid    = ctl_w[NUM_SITES].vld && ctl_w[NUM_SITES].cmd == CMD_QUERY;
	assign nearest_site = bestk_w[NUM_SITES];
	assign en           = !out_valid || out_ready;
	assign in_ready     = en;

	// chain head: pixel centre is pixel plus one half
	assign ctl_w[0].vld = in_valid;
	assign ctl_w[0].cmd = cmd;
	assign cx_w[0]      = {pixel_x, HALF};
	assign cy_w[0]      = {pixel_y, HALF};
	assign ldx_w[0]     = site_x;
	assign ldy_w[0]     = site_y;
	assign lidx_w[0]    = site_index;
	assign bestd_w[0]   = '0;
	assign bestk_w[0]   = '0;

	for (genvar k = 0; k < NUM_SITES; k++) begin : g_cell
		nsl_cell #(
			.CELL_ID    (k),
			.NUM_SITES  (NUM_SITES),
			.COORD_BITS (COORD_BITS),
			.FRAC_BITS  (FRAC_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (en),
			.l1_sel        (l1_sel_q),
			.ctl_i         (ctl_w[k]),
			.cx_i          (cx_w[k]),
			.cy_i          (cy_w[k]),
			.ldx_i         (ldx_w[k]),
			.ldy_i         (ldy_w[k]),
			.lidx_i        (lidx_w[k]),
			.bestd_i       (bestd_w[k]),
			.bestk_i       (bestk_w[k]),
			.ctl_o         (ctl_w[k+1]),
			.cx_o          (cx_w[k+1]),
			.cy_o          (cy_w[k+1]),
			.ldx_o         (ldx_w[k+1]),
			.ldy_o         (ldy_w[k+1]),
			.lidx_o        (lidx_w[k+1]),
			.bestd_o       (bestd_w[k+1]),
			.bestk_o       (bestk_w[k+1])
		);
	end

	`NSL_ASSERT_NOW(a_site_in_range, out_valid,
		{1'b0, nearest_site} < (IDX_W+1)'(NUM_SITES), "nearest_site out of range")
	`NSL_ASSERT_NOW(a_stall_only_on_output, !out_valid, in_ready,
		"input stalled with no result waiting")
	`NSL_ASSERT_NEXT(a_stall_holds_result, in_valid && !in_ready, out_valid,
		"result lost while input was stalled")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for nearest_site_labeler_core: site loads and pixel
// queries are streamed with bursty valid and a stalling receiver; labels
// are checked against directed values or a behavioral nearest-site search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import nsl_pkg::*;;

	localparam int NUM_SITES    = 24;
	localparam int COORD_BITS   = 16;
	localparam int FRAC_BITS    = 4;
	localparam int IDX_BITS     = $clog2(NUM_SITES);
	localparam int HALF_PIXEL   = 1 << (FRAC_BITS - 1);
	localparam int DRAIN_CYCLES = 2 * NUM_SITES + 8;
	localparam int PHASE_ITEMS  = 325;
	localparam int NO_CHECK     = -1;
	localparam int NUM_ROWS     = 21;
	localparam longint SIM_LIMIT_NS = 2_000_000;

	localparam logic SEL_EUCLID    = 1'b0;
	localparam logic SEL_MANHATTAN = 1'b1;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic                  cmd;
		logic [IDX_BITS-1:0]   idx;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [PIX_BITS-1:0]   px;
		logic [PIX_BITS-1:0]   py;
	} txn_t;

	typedef struct packed {
		txn_t t;
		int   want;
	} stim_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data     = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  cmd          = CMD_LOAD;
	logic [IDX_BITS-1:0]   site_index   = '0;
	logic [COORD_BITS-1:0] site_x       = '0;
	logic [COORD_BITS-1:0] site_y       = '0;
	logic [PIX_BITS-1:0]   pixel_x      = '0;
	logic [PIX_BITS-1:0]   pixel_y      = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [IDX_BITS-1:0]   nearest_site;

	// bench copy of the site table and the metric
	logic [COORD_BITS-1:0] site_x_mem [NUM_SITES];
	logic [COORD_BITS-1:0] site_y_mem [NUM_SITES];
	logic                  manhattan_sel = SEL_EUCLID;

	logic [IDX_BITS-1:0] expected_labels [$];
	int                  error_count = 0;
	rx_mode_t            rx_mode     = RX_ALWAYS;
	bit                  tx_bursty   = 1'b0;
	int                  burst_left  = 0;
	int unsigned         cycle_count = 0;
	stim_row_t           directed_rows [NUM_ROWS];

	nearest_site_labeler_core #(
		.NUM_SITES  (NUM_SITES),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.site_index   (site_index),
		.site_x       (site_x),
		.site_y       (site_y),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.nearest_site (nearest_site)
	);

	always #4 clk = ~clk;

	initial begin
		#(SIM_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [IDX_BITS-1:0] closest_site(input logic [PIX_BITS-1:0] px,
			input logic [PIX_BITS-1:0] py);
		longint unsigned cx, cy, sx, sy, dx, dy, d, best_d;
		int best_k;
		cx = 64'(px) * (64'd1 << FRAC_BITS) + HALF_PIXEL;
		cy = 64'(py) * (64'd1 << FRAC_BITS) + HALF_PIXEL;
		best_d = 0;
		best_k = 0;
		for (int k = 0; k < NUM_SITES; k++) begin
			sx = 64'(site_x_mem[k]);
			sy = 64'(site_y_mem[k]);
			dx = (cx >= sx) ? cx - sx : sx - cx;
			dy = (cy >= sy) ? cy - sy : sy - cy;
			d  = manhattan_sel ? dx + dy : dx * dx + dy * dy;
			// strict compare keeps the lowest index on ties
			if (k == 0 || d < best_d) begin
				best_d = d;
				best_k = k;
			end
		end
		return best_k[IDX_BITS-1:0];
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case (rx_mode)
			RX_ALWAYS: begin
				out_ready <= 1'b1;
			end
			RX_RANDOM: begin
				out_ready <= ($urandom_range(0, 99) >= 30);
			end
			default: begin
				out_ready <= ((cycle_count % 11) > 3);
			end
		endcase
	end

	// result checker
	always @(posedge clk) begin
		logic [IDX_BITS-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_labels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d",
					$time, nearest_site);
				error_count++;
			end else begin
				want = expected_labels.pop_front();
				if (nearest_site !== want) begin
					$display("%0t: nearest_site mismatch, expected %0d, actual %0d",
						$time, want, nearest_site);
					error_count++;
				end
			end
		end
	end

	task automatic issue(input txn_t t, input int want);
		int gap;
		in_valid   <= 1'b1;
		cmd        <= t.cmd;
		site_index <= t.idx;
		site_x     <= t.sx;
		site_y     <= t.sy;
		pixel_x    <= t.px;
		pixel_y    <= t.py;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (t.cmd == CMD_LOAD) begin
			// out of range indexes are dropped by the block
			if (t.idx < NUM_SITES) begin
				site_x_mem[t.idx] = t.sx;
				site_y_mem[t.idx] = t.sy;
			end
		end else begin
			expected_labels.push_back((want >= 0) ? want[IDX_BITS-1:0]
				: closest_site(t.px, t.py));
		end
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	// no results pending and the chain flushed of loads
	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_labels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_metric(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		manhattan_sel = value;
	endtask

	function automatic logic [PIX_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c);
		int p;
		p = int'(c >> FRAC_BITS) + int'($urandom_range(0, 4)) - 2;
		if (p < 0)
			p = 0;
		if (p > (1 << PIX_BITS) - 1)
			p = (1 << PIX_BITS) - 1;
		return p[PIX_BITS-1:0];
	endfunction

	function automatic txn_t random_txn();
		txn_t t;
		int r, k;
		r = $urandom_range(0, 99);
		t.sx = COORD_BITS'($urandom);
		t.sy = COORD_BITS'($urandom);
		t.px = PIX_BITS'($urandom);
		t.py = PIX_BITS'($urandom);
		if (r < 3) begin
			t.cmd = CMD_LOAD;
			t.idx = IDX_BITS'($urandom_range(NUM_SITES, (1 << IDX_BITS) - 1));
		end else if (r < 18) begin
			t.cmd = CMD_LOAD;
			t.idx = IDX_BITS'($urandom_range(0, NUM_SITES - 1));
			k = $urandom_range(0, NUM_SITES - 1);
			case ($urandom_range(0, 7))
				0: begin
					// duplicate position to force ties
					t.sx = site_x_mem[k];
					t.sy = site_y_mem[k];
				end
				1, 2: begin
					t.sx = COORD_BITS'(32'h7C00 + $urandom_range(0, 16'h07FF));
					t.sy = COORD_BITS'(32'h7C00 + $urandom_range(0, 16'h07FF));
				end
				default: begin
				end
			endcase
		end else begin
			t.cmd = CMD_QUERY;
			t.idx = IDX_BITS'($urandom);
			if ($urandom_range(0, 1) == 1) begin
				k = $urandom_range(0, NUM_SITES - 1);
				t.px = near_coord(site_x_mem[k]);
				t.py = near_coord(site_y_mem[k]);
			end
		end
		return t;
	endfunction

	task automatic random_phase(input logic metric, input rx_mode_t rx, input bit bursty);
		quiesce();
		write_metric(metric);
		rx_mode   = rx;
		tx_bursty = bursty;
		for (int n = 0; n < PHASE_ITEMS; n++)
			issue(random_txn(), NO_CHECK);
	endtask

	initial begin
		txn_t t;
		directed_rows = '{
			'{'{CMD_QUERY, 5'd0,  16'hFFFF, 16'hFFFF, 12'd0,    12'd0},    0},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd4095, 12'd4095}, 0},
			'{'{CMD_QUERY, 5'd31, 16'h0000, 16'h0000, 12'd0,    12'd4095}, 0},
			'{'{CMD_LOAD,  5'd23, 16'hFFFF, 16'hFFFF, 12'd4095, 12'd4095}, NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd4095, 12'd4095}, 23},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd0,    12'd0},    0},
			'{'{CMD_LOAD,  5'd31, 16'h8000, 16'h8000, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_LOAD,  5'd24, 16'h8000, 16'h8000, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd2048, 12'd2048}, NO_CHECK},
			'{'{CMD_LOAD,  5'd5,  16'h0008, 16'h0008, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd0,    12'd0},    5},
			'{'{CMD_LOAD,  5'd6,  16'h0008, 16'h0018, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_LOAD,  5'd7,  16'h0018, 16'h0008, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd1,    12'd1},    6},
			'{'{CMD_LOAD,  5'd12, 16'h7FF8, 16'h7FF8, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd2047, 12'd2047}, 12},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd4095, 12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd1000, 12'd3000}, NO_CHECK},
			'{'{CMD_LOAD,  5'd1,  16'hFFFF, 16'h0000, 12'd0,    12'd0},    NO_CHECK},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd4095, 12'd0},    1},
			'{'{CMD_QUERY, 5'd0,  16'h0000, 16'h0000, 12'd2048, 12'd2048}, NO_CHECK}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_metric(SEL_EUCLID);

		// every site written before the first query
		rx_mode = RX_ALWAYS;
		for (int k = 0; k < NUM_SITES; k++) begin
			t = '{CMD_LOAD, k[IDX_BITS-1:0], 16'h0000, 16'h0000, 12'd0, 12'd0};
			issue(t, NO_CHECK);
		end

		rx_mode   = RX_RANDOM;
		tx_bursty = 1'b1;
		for (int n = 0; n < NUM_ROWS; n++)
			issue(directed_rows[n].t, directed_rows[n].want);

		// spread the sites out before the random traffic
		tx_bursty = 1'b0;
		for (int k = 0; k < NUM_SITES; k++) begin
			t = '{CMD_LOAD, k[IDX_BITS-1:0], 16'($urandom), 16'($urandom), 12'd0, 12'd0};
			issue(t, NO_CHECK);
		end

		random_phase(SEL_MANHATTAN, RX_PERIODIC, 1'b1);
		random_phase(SEL_EUCLID,    RX_ALWAYS,   1'b0);
		random_phase(SEL_MANHATTAN, RX_RANDOM,   1'b1);
		random_phase(SEL_EUCLID,    RX_PERIODIC, 1'b0);

		quiesce();
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== nearest_site_labeler_core.f =====
+incdir+rtl
rtl/nsl_pkg.sv
rtl/nsl_cell.sv
rtl/nearest_site_labeler_core.sv
verif/tb_top.sv
